// ===== rtl/core/olir_pkg.sv =====
// Shared constants for the ordered list insert/remove unit.
// Operation and status codes, default sizes. No dependencies.
package olir_pkg;

	localparam int CAPACITY_DEF = 16;
	localparam int WORD_WIDTH   = 32;

	localparam logic [1:0] KIND_INSERT    = 2'd0;
	localparam logic [1:0] KIND_REMOVE_AT = 2'd1;
	localparam logic [1:0] KIND_REMOVE_BY = 2'd2;
	localparam logic [1:0] KIND_ENUMERATE = 2'd3;

	localparam logic [1:0] STATUS_OK        = 2'd0;
	localparam logic [1:0] STATUS_FULL      = 2'd1;
	localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;
	localparam logic [1:0] STATUS_ZERO_WORD = 2'd3;

	typedef logic [WORD_WIDTH-1:0] word_t;

endpackage

// ===== rtl/core/olir_if.sv =====
// Channel interfaces for the ordered list unit: request, result and config.
// Depends on olir_pkg for the word type.
interface olir_req_if;
	logic                valid;
	logic                ready;
	logic [1:0]          kind;
	logic [4:0]          position;
	olir_pkg::word_t     data_word;

	modport source (output valid, kind, position, data_word, input ready);
	modport sink   (input valid, kind, position, data_word, output ready);
endinterface

interface olir_rsp_if;
	logic                valid;
	logic                ready;
	logic [1:0]          status;
	olir_pkg::word_t     item_value;
	logic [3:0]          item_index;
	logic [4:0]          entry_count;
	logic                last;
	logic                list_empty;

	modport source (output valid, status, item_value, item_index, entry_count, last,
		list_empty, input ready);
	modport sink   (input valid, status, item_value, item_index, entry_count, last,
		list_empty, output ready);
endinterface

interface olir_cfg_if;
	logic                valid;
	logic                ready;
	olir_pkg::word_t     data;

	modport source (output valid, data, input ready);
	modport sink   (input valid, data, output ready);
endinterface

// ===== rtl/core/ordered_list_insert_remove_unit.sv =====
// Ordered list of words in shift cells, with one shared comparator and sequencer.
// Insert and remove-at: accept, execute when output is free, result registered.
// Remove-by-value: one comparator walks the cells from index 0 to the first match.
// Enumerate: one entry per cycle from the shared read port while the output is free.
// Reset clears the count, sequencer and output valid, and sets the mask to all ones;
// the cells are not cleared. Depends on olir_pkg and olir_if.
module ordered_list_insert_remove_unit #(
	parameter int CAPACITY = olir_pkg::CAPACITY_DEF
) (
	input  logic clk,
	input  logic arst_n,
	olir_req_if.sink   req,
	olir_rsp_if.source rsp,
	olir_cfg_if.sink   cfg
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int IW = $clog2(CAPACITY);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EXEC = 2'd1;
	localparam logic [1:0] ST_SCAN = 2'd2;
	localparam logic [1:0] ST_ENUM = 2'd3;

	olir_pkg::word_t cells_q [CAPACITY];
	olir_pkg::word_t mask_q;
	olir_pkg::word_t data_q;
	logic [1:0]      kind_q;
	logic [4:0]      pos_q;
	logic [1:0]      state_q, state_nxt;
	logic [CW-1:0]   count_q, count_nxt;
	logic [CW-1:0]   idx_q, idx_nxt;

	logic            rsp_valid_q;
	logic [1:0]      rsp_status_q;
	olir_pkg::word_t rsp_value_q;
	logic [3:0]      rsp_index_q;
	logic [4:0]      rsp_count_q;
	logic            rsp_last_q;
	logic            rsp_empty_q;

	logic            slot_free;
	logic            emit;
	logic [1:0]      e_status;
	olir_pkg::word_t e_value;
	logic [31:0]     e_index;
	logic [31:0]     e_count;
	logic            e_last;
	logic            e_empty;

	logic            sh_up, sh_dn;
	logic [31:0]     sh_pos;
	logic [31:0]     cnt32, pos32, idx32, ins32;
	olir_pkg::word_t cur_cell;
	logic            hit;

	assign req.ready = (state_q == ST_IDLE);
	assign cfg.ready = 1'b1;
	assign slot_free = !rsp_valid_q || rsp.ready;

	assign cnt32    = 32'(count_q);
	assign pos32    = 32'(pos_q);
	assign idx32    = 32'(idx_q);
	assign ins32    = (pos32 > cnt32) ? cnt32 : pos32;
	assign cur_cell = cells_q[idx_q[IW-1:0]];
	assign hit      = ((cur_cell ^ data_q) & mask_q) == '0;

	always_comb begin
		state_nxt = state_q;
		count_nxt = count_q;
		idx_nxt   = idx_q;
		emit      = 1'b0;
		e_status  = olir_pkg::STATUS_OK;
		e_value   = '0;
		e_index   = '0;
		e_count   = cnt32;
		e_last    = 1'b1;
		e_empty   = 1'b0;
		sh_up     = 1'b0;
		sh_dn     = 1'b0;
		sh_pos    = '0;
		case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					state_nxt = ST_EXEC;
					idx_nxt   = '0;
				end
			end
			ST_EXEC: begin
				case (kind_q)
					olir_pkg::KIND_INSERT: begin
						if (slot_free) begin
							emit      = 1'b1;
							state_nxt = ST_IDLE;
							if (data_q == '0) begin
								e_status = olir_pkg::STATUS_ZERO_WORD;
							end else if (cnt32 >= 32'(CAPACITY)) begin
								e_status = olir_pkg::STATUS_FULL;
							end else begin
								sh_up     = 1'b1;
								sh_pos    = ins32;
								count_nxt = count_q + CW'(1);
								e_index   = ins32;
								e_count   = cnt32 + 32'd1;
							end
						end
					end
					olir_pkg::KIND_REMOVE_AT: begin
						if (slot_free) begin
							emit      = 1'b1;
							state_nxt = ST_IDLE;
							if (pos32 >= cnt32) begin
								e_status = olir_pkg::STATUS_NOT_FOUND;
							end else begin
								sh_dn     = 1'b1;
								sh_pos    = pos32;
								count_nxt = count_q - CW'(1);
								e_index   = pos32;
								e_count   = cnt32 - 32'd1;
							end
						end
					end
					olir_pkg::KIND_REMOVE_BY: begin
						state_nxt = ST_SCAN;
					end
					default: begin
						if (count_q == '0) begin
							if (slot_free) begin
								emit      = 1'b1;
								e_empty   = 1'b1;
								state_nxt = ST_IDLE;
							end
						end else begin
							state_nxt = ST_ENUM;
						end
					end
				endcase
			end
			ST_SCAN: begin
				if (slot_free) begin
					if (idx32 >= cnt32) begin
						emit      = 1'b1;
						e_status  = olir_pkg::STATUS_NOT_FOUND;
						state_nxt = ST_IDLE;
					end else if (hit) begin
						emit      = 1'b1;
						sh_dn     = 1'b1;
						sh_pos    = idx32;
						count_nxt = count_q - CW'(1);
						e_index   = idx32;
						e_count   = cnt32 - 32'd1;
						state_nxt = ST_IDLE;
					end else begin
						idx_nxt = idx_q + CW'(1);
					end
				end
			end
			default: begin
				if (slot_free) begin
					emit    = 1'b1;
					e_value = cur_cell;
					e_index = idx32;
					e_last  = (idx32 + 32'd1) == cnt32;
					idx_nxt = idx_q + CW'(1);
					if (e_last) begin
						state_nxt = ST_IDLE;
					end
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			idx_q       <= '0;
			mask_q      <= '1;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			count_q <= count_nxt;
			idx_q   <= idx_nxt;
			if (cfg.valid) begin
				mask_q <= cfg.data;
			end
			if (emit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			kind_q <= req.kind;
			pos_q  <= req.position;
			data_q <= req.data_word;
		end
		if (emit) begin
			rsp_status_q <= e_status;
			rsp_value_q  <= e_value;
			rsp_index_q  <= e_index[3:0];
			rsp_count_q  <= e_count[4:0];
			rsp_last_q   <= e_last;
			rsp_empty_q  <= e_empty;
		end
		for (int i = 0; i < CAPACITY; i++) begin
			if (sh_up) begin
				if (32'(i) == sh_pos) begin
					cells_q[i] <= data_q;
				end else if (i > 0 && 32'(i) > sh_pos) begin
					cells_q[i] <= cells_q[(i > 0) ? i - 1 : 0];
				end
			end else if (sh_dn) begin
				if (i < CAPACITY - 1 && 32'(i) >= sh_pos) begin
					cells_q[i] <= cells_q[(i < CAPACITY - 1) ? i + 1 : i];
				end
			end
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.status      = rsp_status_q;
	assign rsp.item_value  = rsp_value_q;
	assign rsp.item_index  = rsp_index_q;
	assign rsp.entry_count = rsp_count_q;
	assign rsp.last        = rsp_last_q;
	assign rsp.list_empty  = rsp_empty_q;

endmodule
